[hdl/spg_pkg.sv]
// spg_pkg: shared types, constants and codes for the servo pulse generator
// used by every module in hdl/; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package spg_pkg;

   // channel count and field widths
   localparam int NUM_CHANNELS = 3;
   localparam int PIN_W        = 3;
   localparam int ENABLE_W     = 3;
   localparam int OP_W         = 2;
   localparam int CHAN_W       = 2;
   localparam int VALUE_W      = 16;
   localparam int COUNT_W      = 10;
   localparam int PULSE_W      = 6;
   localparam int US_W         = 12;  // internal microsecond width, bounds never exceed 4095
   localparam int DEG_W        = 8;
   localparam int SCALED_W     = 19; // microseconds times 180, at most 468000
   localparam int RECIP_W      = 20;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;

   // timing constants
   localparam int TICK_US          = 50;
   localparam int FRAME_US_50HZ    = 20000;
   localparam int FRAME_US_25HZ    = 40000;
   localparam logic [COUNT_W-1:0] FRAME_TICKS_50HZ = COUNT_W'(FRAME_US_50HZ / TICK_US);
   localparam logic [COUNT_W-1:0] FRAME_TICKS_25HZ = COUNT_W'(FRAME_US_25HZ / TICK_US);

   // pulse bounds in microseconds
   localparam logic [US_W-1:0] DEF_MIN_US   = US_W'(1000);
   localparam logic [US_W-1:0] DEF_MAX_US   = US_W'(2000);
   localparam logic [US_W-1:0] FLOOR_MIN_US = US_W'(400);
   localparam logic [US_W-1:0] CEIL_MAX_US  = US_W'(2600);
   localparam logic [US_W-1:0] US_SAT       = {US_W{1'b1}};
   localparam logic [DEG_W-1:0] MAX_DEGREES = DEG_W'(180);
   localparam logic [PULSE_W-1:0] DEF_PULSE_TICKS = PULSE_W'(1000 / TICK_US);

   // scaled value y = 180 * us, ticks = y / 9000 done as (y * RECIP) >> RECIP_SHIFT
   localparam int SCALED_DIV  = 180 * TICK_US;
   localparam int RECIP_SHIFT = 33;
   localparam logic [RECIP_W-1:0] RECIP_9000 =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SCALED_DIV) - 64'd1) / 64'(SCALED_DIV));
   localparam int PROD_W = SCALED_W + RECIP_W;

   // channels that exist
   localparam logic [ENABLE_W-1:0] CHAN_MASK = ENABLE_W'((1 << NUM_CHANNELS) - 1);

   // operation codes
   localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_US  = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE_DEG = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_RATE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE     = 3'd1;
   localparam int CSR_BOUND_BASE = 2;

   // configuration as seen by the datapath (bounds pre-clamped on write)
   typedef struct packed {
      logic                                frame_rate_select;
      logic [ENABLE_W-1:0]                 channel_enable;
      logic [NUM_CHANNELS-1:0][US_W-1:0]   min_us;
      logic [NUM_CHANNELS-1:0][US_W-1:0]   max_us;
   } cfg_type;

   // prepared item held in the input register
   typedef struct packed {
      logic                is_tick;
      logic                write_en;
      logic [CHAN_W-1:0]   chan;
      logic [SCALED_W-1:0] scaled;
   } item_type;

endpackage
`default_nettype wire

[hdl/spg_csr.sv]
// spg_csr: configuration registers; bounds are clamped as they are written
// depends on spg_pkg
`timescale 1ns / 1ps
`default_nettype none
module spg_csr
   import spg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff, cfg_in;
   logic [US_W-1:0] min_clamped;
   logic [US_W-1:0] max_clamped;

   // clamp incoming bounds: min up to the floor and down to US_SAT, max down to the ceiling
   always_comb begin
      if (csr_write_data < CSR_DATA_W'(FLOOR_MIN_US)) begin
         min_clamped = FLOOR_MIN_US;
      end else if (csr_write_data > CSR_DATA_W'(US_SAT)) begin
         min_clamped = US_SAT;
      end else begin
         min_clamped = csr_write_data[US_W-1:0];
      end
      if (csr_write_data > CSR_DATA_W'(CEIL_MAX_US)) begin
         max_clamped = CEIL_MAX_US;
      end else begin
         max_clamped = csr_write_data[US_W-1:0];
      end
   end

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         if (csr_index == CSR_FRAME_RATE) begin
            cfg_in.frame_rate_select = csr_write_data[0];
         end
         if (csr_index == CSR_ENABLE) begin
            cfg_in.channel_enable = csr_write_data[ENABLE_W-1:0];
         end
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (csr_index == CSR_INDEX_W'(CSR_BOUND_BASE + 2 * i)) begin
               cfg_in.min_us[i] = min_clamped;
            end
            if (csr_index == CSR_INDEX_W'(CSR_BOUND_BASE + 2 * i + 1)) begin
               cfg_in.max_us[i] = max_clamped;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_rate_select <= 1'b0;
         cfg_ff.channel_enable    <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            cfg_ff.min_us[i] <= DEF_MIN_US;
            cfg_ff.max_us[i] <= DEF_MAX_US;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[hdl/spg_prep.sv]
// spg_prep: front logic ahead of the input register; resolves bounds and
// scales the target pulse to 180 * microseconds; depends on spg_pkg
`timescale 1ns / 1ps
`default_nettype none
module spg_prep
   import spg_pkg::*;
(
   input  wire cfg_type              cfg,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [CHAN_W-1:0]    req_channel,
   input  wire logic [VALUE_W-1:0]   req_value,
   output item_type                  item
);

   logic [US_W-1:0]     sel_min;
   logic [US_W-1:0]     sel_max;
   logic                sel_enabled;
   logic                fallback;
   logic [US_W-1:0]     lo;
   logic [US_W-1:0]     hi;
   logic [US_W-1:0]     span;
   logic [DEG_W-1:0]    deg;
   logic [US_W-1:0]     us_clamped;
   logic [SCALED_W-1:0] scaled_us;
   logic [SCALED_W-1:0] scaled_deg;
   logic                is_write;

   // pick the addressed channel's bounds and enable
   always_comb begin
      sel_min     = DEF_MIN_US;
      sel_max     = DEF_MAX_US;
      sel_enabled = 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (req_channel == CHAN_W'(i)) begin
            sel_min     = cfg.min_us[i];
            sel_max     = cfg.max_us[i];
            sel_enabled = cfg.channel_enable[i];
         end
      end
   end

   // effective bounds, default pair when they cross or are equal
   always_comb begin
      fallback = (sel_min >= sel_max);
      lo       = fallback ? DEF_MIN_US : sel_min;
      hi       = fallback ? DEF_MAX_US : sel_max;
      span     = hi - lo;
   end

   // microsecond write: clamp into bounds
   always_comb begin
      if (req_value < VALUE_W'(lo)) begin
         us_clamped = lo;
      end else if (req_value > VALUE_W'(hi)) begin
         us_clamped = hi;
      end else begin
         us_clamped = req_value[US_W-1:0];
      end
      scaled_us = SCALED_W'(us_clamped) * SCALED_W'(MAX_DEGREES);
   end

   // angle write: 180 * lo + span * deg, divided by 180 later with the tick scale
   always_comb begin
      if (req_value > VALUE_W'(MAX_DEGREES)) begin
         deg = MAX_DEGREES;
      end else begin
         deg = req_value[DEG_W-1:0];
      end
      scaled_deg = SCALED_W'(lo) * SCALED_W'(MAX_DEGREES) + SCALED_W'(span) * SCALED_W'(deg);
   end

   // decode
   always_comb begin
      is_write      = (req_operation == OP_WRITE_US) || (req_operation == OP_WRITE_DEG);
      item.is_tick  = (req_operation == OP_TICK);
      item.write_en = is_write && sel_enabled;
      item.chan     = req_channel;
      item.scaled   = (req_operation == OP_WRITE_DEG) ? scaled_deg : scaled_us;
   end

endmodule
`default_nettype wire

[hdl/spg_engine.sv]
// spg_engine: pulse-length conversion and the frame state (counter, pins,
// stored pulse lengths); its state is the result; depends on spg_pkg
`timescale 1ns / 1ps
`default_nettype none
module spg_engine
   import spg_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire item_type            item,
   input  wire cfg_type             cfg,
   output logic [PIN_W-1:0]         pin_levels,
   output logic [COUNT_W-1:0]       frame_position
);

   logic [COUNT_W-1:0] tick_counter_ff, tick_counter_in;
   logic [PIN_W-1:0]   pin_state_ff, pin_state_in;
   logic [NUM_CHANNELS-1:0][PULSE_W-1:0] pulse_ff, pulse_in;
   logic [PROD_W-1:0]  product;
   logic [PULSE_W-1:0] new_ticks;
   logic [ENABLE_W-1:0] en_mask;
   logic [COUNT_W-1:0] frame_ticks;
   logic [COUNT_W-1:0] counter_inc;

   // ticks = scaled / 9000 by reciprocal multiply
   always_comb begin
      product   = PROD_W'(item.scaled) * PROD_W'(RECIP_9000);
      new_ticks = product[PROD_W-1:RECIP_SHIFT];
   end

   always_comb begin
      en_mask     = cfg.channel_enable & CHAN_MASK;
      frame_ticks = cfg.frame_rate_select ? FRAME_TICKS_25HZ : FRAME_TICKS_50HZ;
      counter_inc = tick_counter_ff + COUNT_W'(1);
   end

   // next state for a tick or a write
   always_comb begin
      tick_counter_in = tick_counter_ff;
      pin_state_in    = pin_state_ff;
      pulse_in        = pulse_ff;
      if (advance) begin
         if (item.is_tick) begin
            if (tick_counter_ff == '0) begin
               pin_state_in = pin_state_in | en_mask;
            end
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (en_mask[i] && (tick_counter_ff == COUNT_W'(pulse_ff[i]))) begin
                  pin_state_in[i] = 1'b0;
               end
            end
            tick_counter_in = (counter_inc >= frame_ticks) ? '0 : counter_inc;
         end else if (item.write_en) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (item.chan == CHAN_W'(i)) begin
                  pulse_in[i] = new_ticks;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_counter_ff <= '0;
         pin_state_ff    <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            pulse_ff[i] <= DEF_PULSE_TICKS;
         end
      end else begin
         tick_counter_ff <= tick_counter_in;
         pin_state_ff    <= pin_state_in;
         pulse_ff        <= pulse_in;
      end
   end

   assign pin_levels     = pin_state_ff;
   assign frame_position = tick_counter_ff;

`ifndef SYNTHESIS
   // counter never reaches the long frame length
   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      tick_counter_ff < FRAME_TICKS_25HZ)
      else $error("frame counter out of range");

   // counter moves only on a tick transfer
   a_counter_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && item.is_tick) |=> $stable(tick_counter_ff))
      else $error("frame counter moved without a tick");

   // disabled pins hold their level
   a_disabled_hold: assert property (@(posedge clock) disable iff (reset)
      advance |=> ((pin_state_ff ^ $past(pin_state_ff)) & ~$past(en_mask)) == '0)
      else $error("disabled pin changed");

   // channel 0's stored pulse length stays inside the floor and ceiling bounds
   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      pulse_ff[0] >= PULSE_W'(FLOOR_MIN_US / US_W'(TICK_US))
      && pulse_ff[0] <= PULSE_W'(CEIL_MAX_US / US_W'(TICK_US)))
      else $error("pulse length out of bounds");
`endif

endmodule
`default_nettype wire

[hdl/servo_pulse_generator_top.sv]
// servo_pulse_generator_top: handshake, input register and result stage of the
// three-channel servo pulse generator; depends on spg_pkg, spg_csr, spg_prep, spg_engine
// a transferred request waits in the input register and moves into the result stage
// when that stage is empty or its result is being taken
// throughput: one item per cycle; the input register can still take an item while a
// result waits, stalling only when both stages are full and the result is not taken
// reset: synchronous; registers return to their reset values, pulses to 20 ticks,
// frame counter and pins to zero, both pipeline stages empty
`timescale 1ns / 1ps
`default_nettype none
module servo_pulse_generator_top
   import spg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [OP_W-1:0]        req_operation,
   input  wire logic [CHAN_W-1:0]      req_channel,
   input  wire logic [VALUE_W-1:0]     req_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [PIN_W-1:0]            rsp_pin_levels,
   output logic [COUNT_W-1:0]          rsp_frame_position,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type  cfg;
   item_type prep_item;
   item_type item_ff;
   logic     item_valid_ff, item_valid_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     advance;
   logic     req_xfer;

   spg_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   spg_prep u_prep (
      .cfg           (cfg),
      .req_operation (req_operation),
      .req_channel   (req_channel),
      .req_value     (req_value),
      .item          (prep_item)
   );

   // stage handshake
   always_comb begin
      advance       = item_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready     = !item_valid_ff || advance;
      req_xfer      = req_valid && req_ready;
      item_valid_in = req_xfer ? 1'b1 : (advance ? 1'b0 : item_valid_ff);
      rsp_valid_in  = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= prep_item;
      end
   end

   spg_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .item           (item_ff),
      .cfg            (cfg),
      .pin_levels     (rsp_pin_levels),
      .frame_position (rsp_frame_position)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[tb/servo_pulse_generator_top_tb.sv]
`timescale 1ns / 1ps
// servo_pulse_generator_top_tb: self-checking testbench for the servo pulse generator
// depends on spg_pkg and servo_pulse_generator_top; predicts pins and frame counter per transfer
module servo_pulse_generator_top_tb;
   import spg_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int LONG_HOLD    = 300;
   localparam int MAX_REPORTS  = 10;

   // codes with no name in the package
   localparam logic [OP_W-1:0]   OP_RESERVED = 2'd3;
   localparam logic [CHAN_W-1:0] CHAN_NONE   = 2'd3;

   typedef struct packed {
      logic [PIN_W-1:0]   pins;
      logic [COUNT_W-1:0] position;
   } servo_status_type;

   typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   wire                    req_ready;
   logic [OP_W-1:0]        req_operation = OP_TICK;
   logic [CHAN_W-1:0]      req_channel = '0;
   logic [VALUE_W-1:0]     req_value = '0;
   wire                    rsp_valid;
   logic                   rsp_ready = 1'b0;
   wire [PIN_W-1:0]        rsp_pin_levels;
   wire [COUNT_W-1:0]      rsp_frame_position;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_FRAME_RATE;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // predicted configuration and state
   logic                 cfg_rate;
   logic [ENABLE_W-1:0]  cfg_enable;
   logic [VALUE_W-1:0]   cfg_min_us [NUM_CHANNELS];
   logic [VALUE_W-1:0]   cfg_max_us [NUM_CHANNELS];
   logic [COUNT_W-1:0]   frame_count;
   logic [PULSE_W-1:0]   pulse_ticks [NUM_CHANNELS];
   logic [PIN_W-1:0]     pin_levels;
   servo_status_type     expected_status [$];

   int cycle_count   = 0;
   int error_count   = 0;
   int burst_left    = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   logic [7:0]  stall_phase = '0;
   rx_mode_type stall_mode  = RX_STREAM;

   servo_pulse_generator_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_channel        (req_channel),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pin_levels     (rsp_pin_levels),
      .rsp_frame_position (rsp_frame_position),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // effective pulse bounds of a channel in microseconds
   function automatic void pulse_bounds(input int ch, output int lo, output int hi);
      lo = (cfg_min_us[ch] < FLOOR_MIN_US) ? FLOOR_MIN_US : cfg_min_us[ch];
      hi = (cfg_max_us[ch] > CEIL_MAX_US) ? CEIL_MAX_US : cfg_max_us[ch];
      if (lo >= hi) begin
         lo = DEF_MIN_US;
         hi = DEF_MAX_US;
      end
   endfunction

   // advance the predicted generator by one item and queue its status
   function automatic void predict_servo_item(input logic [OP_W-1:0] op,
                                              input logic [CHAN_W-1:0] ch,
                                              input logic [VALUE_W-1:0] val);
      int lo, hi, us, deg, i;
      servo_status_type status;
      if (op == OP_TICK) begin
         // enabled pins rise at frame start, each falls at its own pulse length
         if (frame_count == '0) pin_levels = pin_levels | cfg_enable;
         for (i = 0; i < NUM_CHANNELS; i++) begin
            if (cfg_enable[i] && frame_count == COUNT_W'(pulse_ticks[i])) pin_levels[i] = 1'b0;
         end
         frame_count = frame_count + 1'b1;
         if (frame_count >= (cfg_rate ? FRAME_TICKS_25HZ : FRAME_TICKS_50HZ)) frame_count = '0;
      end else if ((op == OP_WRITE_US || op == OP_WRITE_DEG) && ch < NUM_CHANNELS
                   && cfg_enable[ch]) begin
         pulse_bounds(ch, lo, hi);
         if (op == OP_WRITE_US) begin
            us = val;
         end else begin
            deg = (val > MAX_DEGREES) ? int'(MAX_DEGREES) : int'(val);
            us = lo + (hi - lo) * deg / int'(MAX_DEGREES);
         end
         if (us < lo) us = lo;
         if (us > hi) us = hi;
         pulse_ticks[ch] = PULSE_W'(us / TICK_US);
      end
      status.pins     = pin_levels;
      status.position = frame_count;
      expected_status.push_back(status);
   endfunction

   // register write, only while the block is idle
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      int slot;
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      slot = int'(index) - CSR_BOUND_BASE;
      if (index == CSR_FRAME_RATE) cfg_rate = data[0];
      else if (index == CSR_ENABLE) cfg_enable = data[ENABLE_W-1:0];
      else if (slot % 2 == 0) cfg_min_us[slot / 2] = data;
      else cfg_max_us[slot / 2] = data;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_bounds(input int ch, input logic [VALUE_W-1:0] lo_us,
                             input logic [VALUE_W-1:0] hi_us);
      write_register(CSR_INDEX_W'(CSR_BOUND_BASE + 2 * ch), lo_us);
      write_register(CSR_INDEX_W'(CSR_BOUND_BASE + 2 * ch + 1), hi_us);
   endtask

   // offer one item, in bursts with random gaps, and return at its transfer
   task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                            input logic [VALUE_W-1:0] val);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_channel   <= ch;
      req_value     <= val;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and let every expected status come back
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // capture every request transfer into the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         predict_servo_item(req_operation, req_channel, req_value);
   end

   // compare every result transfer with the oldest prediction
   always @(posedge clock) begin : check_results
      servo_status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result at cycle %0d: pins %b position %0d",
                        cycle_count, rsp_pin_levels, rsp_frame_position);
         end else begin
            want = expected_status.pop_front();
            if (rsp_pin_levels !== want.pins || rsp_frame_position !== want.position) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("mismatch at cycle %0d: pins exp %b got %b, position exp %0d got %0d",
                           cycle_count, want.pins, rsp_pin_levels, want.position,
                           rsp_frame_position);
            end
         end
      end
   end

   // receiver: stall pattern changes each time the 8-bit phase counter wraps, long hold on request
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      if (stall_phase == '0) stall_mode <= rx_mode_type'($urandom_range(0, 3));
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= LONG_HOLD;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            RX_STREAM:   rsp_ready <= 1'b1;
            RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: rsp_ready <= (stall_phase[2:0] < 3'd3);
         endcase
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // field extremes, every operation, ignored writes, clamping and bound fallback
   task automatic test_directed_fields();
      send_item(OP_WRITE_US, 2'd0, 16'd1500);
      send_item(OP_TICK, 2'd0, 16'hFFFF);
      send_item(OP_RESERVED, CHAN_NONE, 16'hFFFF);
      wait_until_idle();
      write_register(CSR_ENABLE, 16'h7);
      // clamping in microseconds, saturation in degrees, channel 3 ignored
      send_item(OP_WRITE_US, 2'd0, 16'd0);
      send_item(OP_WRITE_US, 2'd1, 16'hFFFF);
      send_item(OP_WRITE_US, 2'd2, 16'd1234);
      send_item(OP_WRITE_DEG, 2'd0, 16'd0);
      send_item(OP_WRITE_DEG, 2'd1, 16'd180);
      send_item(OP_WRITE_DEG, 2'd2, 16'd181);
      send_item(OP_WRITE_DEG, 2'd0, 16'hFFFF);
      send_item(OP_WRITE_US, CHAN_NONE, 16'd2000);
      send_item(OP_WRITE_DEG, CHAN_NONE, 16'd90);
      send_item(OP_TICK, CHAN_NONE, 16'h0000);
      wait_until_idle();
      // widest bounds, inverted bounds, equal bounds
      set_bounds(0, 16'd0, 16'hFFFF);
      set_bounds(1, 16'd3000, 16'd100);
      set_bounds(2, 16'd1500, 16'd1500);
      send_item(OP_WRITE_US, 2'd0, 16'd0);
      send_item(OP_WRITE_US, 2'd0, 16'hFFFF);
      send_item(OP_WRITE_DEG, 2'd1, 16'd90);
      send_item(OP_WRITE_DEG, 2'd2, 16'd45);
      send_item(OP_TICK, 2'd1, 16'h5555);
      send_item(OP_TICK, 2'd2, 16'hAAAA);
      wait_until_idle();
   endtask

   // long frame past 400, then short frame wraps; disabled pin holds high
   task automatic test_frame_shrink_and_hold();
      int start, count;
      write_register(CSR_FRAME_RATE, 16'd1);
      send_item(OP_WRITE_US, 2'd0, 16'd2600);
      send_item(OP_WRITE_US, 2'd1, 16'd2600);
      send_item(OP_WRITE_DEG, 2'd2, 16'd90);
      wait_until_idle();
      // narrower bounds leave the stored pulse as it is
      set_bounds(0, 16'd1000, 16'd1200);
      start = frame_count;
      count = (start < 400) ? 400 - start + $urandom_range(0, 300)
                            : $urandom_range(0, 799 - start);
      repeat (count) send_item(OP_TICK, CHAN_W'($urandom_range(0, 3)), VALUE_W'($urandom));
      wait_until_idle();
      write_register(CSR_FRAME_RATE, 16'd0);
      repeat (12) send_item(OP_TICK, CHAN_W'($urandom_range(0, 3)), VALUE_W'($urandom));
      wait_until_idle();
      write_register(CSR_ENABLE, 16'b101);
      repeat (70) send_item(OP_TICK, CHAN_W'($urandom_range(0, 3)), VALUE_W'($urandom));
      wait_until_idle();
      write_register(CSR_ENABLE, 16'h7);
   endtask

   // receiver holds off while items keep coming, so the input stalls
   task automatic test_backpressure();
      logic [OP_W-1:0] op;
      hold_requests++;
      repeat (60) begin
         op = ($urandom_range(0, 3) == 0) ? OP_WRITE_US : OP_TICK;
         send_item(op, CHAN_W'($urandom_range(0, 3)), VALUE_W'($urandom));
      end
      wait_until_idle();
   endtask

   // several configurations, each followed by mostly ticks with random writes
   task automatic test_random_phases();
      int phase, ch, pick;
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] val;
      for (phase = 0; phase < 8; phase++) begin
         write_register(CSR_FRAME_RATE, (phase == 0) ? 16'd0 : (phase == 7) ? 16'd1
                                        : CSR_DATA_W'($urandom_range(0, 1)));
         write_register(CSR_ENABLE, (phase == 0 || phase == 7) ? 16'h7 : (phase == 3) ? 16'h0
                                    : CSR_DATA_W'($urandom_range(0, 7)));
         for (ch = 0; ch < NUM_CHANNELS; ch++) begin
            case ($urandom_range(0, 5))
               0: set_bounds(ch, VALUE_W'($urandom_range(0, 399)),
                             VALUE_W'($urandom_range(2601, 65535)));
               1: set_bounds(ch, VALUE_W'($urandom_range(500, 1500)),
                             VALUE_W'($urandom_range(1600, 2500)));
               2: set_bounds(ch, VALUE_W'($urandom_range(1500, 2600)),
                             VALUE_W'($urandom_range(400, 1500)));
               3: set_bounds(ch, VALUE_W'($urandom), VALUE_W'($urandom));
               4: set_bounds(ch, 16'd0, 16'hFFFF);
               default: set_bounds(ch, 16'hFFFF, 16'd0);
            endcase
         end
         repeat (170) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) op = OP_TICK;
            else if (pick < 89) op = OP_WRITE_US;
            else if (pick < 98) op = OP_WRITE_DEG;
            else op = OP_RESERVED;
            val = VALUE_W'($urandom);
            if (op == OP_WRITE_US && $urandom_range(0, 1) == 1)
               val = VALUE_W'($urandom_range(300, 2700));
            if (op == OP_WRITE_DEG && $urandom_range(0, 2) != 0)
               val = VALUE_W'($urandom_range(0, 200));
            send_item(op, CHAN_W'($urandom_range(0, 3)), val);
         end
         wait_until_idle();
      end
   endtask

   initial begin
      cfg_rate    = 1'b0;
      cfg_enable  = '0;
      frame_count = '0;
      pin_levels  = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         cfg_min_us[i]  = VALUE_W'(DEF_MIN_US);
         cfg_max_us[i]  = VALUE_W'(DEF_MAX_US);
         pulse_ticks[i] = DEF_PULSE_TICKS;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_fields();
      test_frame_shrink_and_hold();
      test_backpressure();
      test_random_phases();
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
